// ===== rtl/core/ord_pkg.sv =====
// ----------------------------------------------------------------------------
// ord_pkg
// Shared types and codes for the output-restricted deque.
// ----------------------------------------------------------------------------
package ord_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam req_t REQ_PUSH_FRONT = 3'd0;
    localparam req_t REQ_PUSH_REAR  = 3'd1;
    localparam req_t REQ_POP_FRONT  = 3'd2;
    localparam req_t REQ_PEEK_FRONT = 3'd3;
    localparam req_t REQ_PEEK_REAR  = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic shift_in;   // push front: take the entry of the previous cell
        logic append;     // push rear: first free cell takes the new value
        logic shift_out;  // pop: take the entry of the next cell
    } cell_ctl_t;

endpackage

// ===== rtl/core/ord_cell.sv =====
// ----------------------------------------------------------------------------
// ord_cell
// One storage cell of the deque row: an entry and its occupied bit.
// ----------------------------------------------------------------------------
module ord_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  ord_pkg::cell_ctl_t ctl,
    input  ord_pkg::data_t     in_value,
    input  ord_pkg::data_t     prev_data,
    input  logic               prev_valid,
    input  ord_pkg::data_t     next_data,
    input  logic               next_valid,
    output ord_pkg::data_t     data,
    output logic               valid
);

    ord_pkg::data_t data_reg;
    ord_pkg::data_t data_next;
    logic           valid_reg;
    logic           valid_next;

    always_comb
    begin
        priority if (ctl.shift_in)
        begin
            data_next  = prev_data;
            valid_next = prev_valid;
        end
        else if (ctl.shift_out)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (ctl.append && !valid_reg && prev_valid)
        begin
            data_next  = in_value;
            valid_next = 1'b1;
        end
        else
        begin
            data_next  = data_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/core/output_restricted_deque.sv =====
// ----------------------------------------------------------------------------
// output_restricted_deque
// Result strobe (done) is registered: it rises in the cycle after the request beat.
// Throughput: one request per cycle; busy stays low, set by the single
// update of the cell row. Reset clears every occupied bit (deque empty);
// entries hold no reset value. Results cannot be stalled by the receiver.
// Deque kept as a row of cells, front at cell 0, packed toward the front.
// ----------------------------------------------------------------------------
module output_restricted_deque
#(
    parameter int DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            req_type,
    input  logic signed [31:0]    value,
    output logic                  done,
    output logic [1:0]            status,
    output logic signed [31:0]    out_value,
    output logic                  now_empty,
    output logic                  now_full
);

    ord_pkg::data_t     cell_data  [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    ord_pkg::cell_ctl_t ctl;

    ord_pkg::data_t   rear_reg;
    ord_pkg::data_t   rear_next;
    logic             done_reg;
    ord_pkg::status_t status_reg;
    ord_pkg::status_t status_next;
    ord_pkg::data_t   out_value_reg;
    ord_pkg::data_t   out_value_next;
    logic             now_empty_reg;
    logic             now_empty_next;
    logic             now_full_reg;
    logic             now_full_next;

    logic accept;
    logic is_empty;
    logic is_full;

    assign accept   = start && !busy;
    assign busy     = 1'b0;
    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];

    always_comb
    begin
        ctl            = '0;
        rear_next      = rear_reg;
        status_next    = ord_pkg::ST_OK;
        out_value_next = '0;
        now_empty_next = is_empty;
        now_full_next  = is_full;
        if (accept)
        begin
            unique case (req_type)
                ord_pkg::REQ_PUSH_FRONT,
                ord_pkg::REQ_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ord_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (req_type == ord_pkg::REQ_PUSH_FRONT)
                        begin
                            ctl.shift_in = 1'b1;
                        end
                        else
                        begin
                            ctl.append = 1'b1;
                        end
                        if (is_empty || req_type == ord_pkg::REQ_PUSH_REAR)
                        begin
                            rear_next = value;
                        end
                        now_empty_next = 1'b0;
                        now_full_next  = cell_valid[DEPTH-2];
                    end
                end
                ord_pkg::REQ_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ord_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.shift_out  = 1'b1;
                        out_value_next = cell_data[0];
                        now_empty_next = !cell_valid[1];
                        now_full_next  = 1'b0;
                    end
                end
                ord_pkg::REQ_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ord_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_value_next = cell_data[0];
                    end
                end
                ord_pkg::REQ_PEEK_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ord_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_value_next = rear_reg;
                    end
                end
                default:
                begin
                    // unused codes: no change, flags report current state
                end
            endcase
        end
    end

    // cell 0 sees the request value as an always-occupied predecessor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ord_pkg::data_t prev_d;
        logic           prev_v;
        ord_pkg::data_t next_d;
        logic           next_v;

        if (i == 0)
        begin : g_first
            assign prev_d = value;
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[i-1];
            assign prev_v = cell_valid[i-1];
        end

        if (i == DEPTH-1)
        begin : g_last
            assign next_d = cell_data[i];
            assign next_v = 1'b0;
        end
        else
        begin : g_inner
            assign next_d = cell_data[i+1];
            assign next_v = cell_valid[i+1];
        end

        ord_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .in_value   (value),
            .prev_data  (prev_d),
            .prev_valid (prev_v),
            .next_data  (next_d),
            .next_valid (next_v),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rear_reg      <= rear_next;
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        now_empty_reg <= now_empty_next;
        now_full_reg  <= now_full_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

endmodule

// ===== rtl/core/ord_checker.sv =====
// ----------------------------------------------------------------------------
// ord_checker
// Port-level checks on the deque's request and result beats.
// ----------------------------------------------------------------------------
module ord_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic               now_empty,
    input logic               now_full
);

    // every request beat yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("request beat without result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without request beat");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ord_pkg::ST_FULL |-> now_full)
        else $error("full rejection while not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ord_pkg::ST_EMPTY |-> now_empty)
        else $error("empty rejection while not empty");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(now_empty && now_full))
        else $error("deque reported both empty and full");

endmodule

bind output_restricted_deque ord_checker u_ord_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .now_empty (now_empty),
    .now_full  (now_full)
);

// ===== bench/deque_monitor.sv =====
// ----------------------------------------------------------------------------
// deque_monitor
// Watches the request and result channels of the output-restricted deque,
// tracks the deque contents on its own, and compares every result beat
// against the oldest prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module deque_monitor
    import ord_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  req_t    req_type,
    input  data_t   value,
    input  logic    done,
    input  status_t status,
    input  data_t   out_value,
    input  logic    now_empty,
    input  logic    now_full,
    output int      errors,
    output int      pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t status;
        data_t   val;
        logic    empty;
        logic    full;
    } deque_result_t;

    data_t         slot_mem [DEPTH];
    int            head_ptr;
    int            tail_ptr;
    logic          is_empty;
    deque_result_t result_q [$];
    int            beat_count;

    function automatic int ptr_next(int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int ptr_prev(int i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic logic deque_full();
        return !is_empty && (ptr_next(tail_ptr) == head_ptr);
    endfunction

    // advance the shadow deque by one request and return what it should answer
    function automatic deque_result_t deque_step(req_t req, data_t val);
        deque_result_t r;
        r.status = ST_OK;
        r.val    = '0;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (deque_full())
                begin
                    r.status = ST_FULL;
                end
                else if (is_empty)
                begin
                    head_ptr    = 0;
                    tail_ptr    = 0;
                    is_empty    = 1'b0;
                    slot_mem[0] = val;
                end
                else if (req == REQ_PUSH_FRONT)
                begin
                    head_ptr           = ptr_prev(head_ptr);
                    slot_mem[head_ptr] = val;
                end
                else
                begin
                    tail_ptr           = ptr_next(tail_ptr);
                    slot_mem[tail_ptr] = val;
                end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_PEEK_REAR:
            begin
                if (is_empty)
                begin
                    r.status = ST_EMPTY;
                end
                else if (req == REQ_PEEK_REAR)
                begin
                    r.val = slot_mem[tail_ptr];
                end
                else
                begin
                    r.val = slot_mem[head_ptr];
                    if (req == REQ_POP_FRONT)
                    begin
                        // last entry leaves: pointers go home
                        if (head_ptr == tail_ptr)
                        begin
                            is_empty = 1'b1;
                            head_ptr = 0;
                            tail_ptr = 0;
                        end
                        else
                        begin
                            head_ptr = ptr_next(head_ptr);
                        end
                    end
                end
            end
            default:
            begin
                // spare codes: no effect, ok status
            end
        endcase
        r.empty = is_empty;
        r.full  = deque_full();
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: result %0d: %s", $realtime, beat_count, msg);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : track
        deque_result_t want;
        if (!rst_n)
        begin
            head_ptr   = 0;
            tail_ptr   = 0;
            is_empty   = 1'b1;
            beat_count = 0;
            result_q.delete();
            pending    = 0;
        end
        else
        begin
            // push first, so a same-cycle answer would still find its entry
            if (start && !busy)
            begin
                result_q.push_back(deque_step(req_type, value));
            end
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("result beat with no request outstanding");
                end
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (out_value !== want.val)
                        report_mismatch($sformatf("out_value %0d, expected %0d",
                                                  out_value, want.val));
                    if (now_empty !== want.empty)
                        report_mismatch($sformatf("now_empty %b, expected %b",
                                                  now_empty, want.empty));
                    if (now_full !== want.full)
                        report_mismatch($sformatf("now_full %b, expected %b",
                                                  now_full, want.full));
                end
                beat_count++;
            end
            pending = result_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the output-restricted deque with a directed sweep of the corner
// cases, then long randomized runs that alternate between filling, draining
// and balanced phases with random gaps between requests. Checking lives in
// deque_monitor; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ord_pkg::*;

    localparam int   DEPTH        = 8;
    localparam int   STALL_LIMIT  = 200;
    localparam int   DRAIN_CYCLES = 4;
    localparam int   RANDOM_ITEMS = 1000;

    // codes the block must ignore
    localparam req_t REQ_SPARE_5  = 3'd5;
    localparam req_t REQ_SPARE_6  = 3'd6;
    localparam req_t REQ_SPARE_7  = 3'd7;

    localparam data_t VAL_MAX     = 32'sh7FFF_FFFF;
    localparam data_t VAL_MIN     = 32'sh8000_0000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    req_t    req_type;
    data_t   value;
    logic    done;
    status_t status;
    data_t   out_value;
    logic    now_empty;
    logic    now_full;

    int      errors;
    int      pending;
    logic    beat_taken;
    int      idle_cycles;
    logic    back_to_back;

    output_restricted_deque #(.DEPTH(DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .done      (done),
        .status    (status),
        .out_value (out_value),
        .now_empty (now_empty),
        .now_full  (now_full)
    );

    deque_monitor #(.DEPTH(DEPTH)) mon
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .done      (done),
        .status    (status),
        .out_value (out_value),
        .now_empty (now_empty),
        .now_full  (now_full),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // registered view of the request handshake, read at the falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_taken <= 1'b0;
        else
            beat_taken <= start && !busy;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[output_restricted_deque] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic issue(req_t req, data_t val);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= req;
        value    <= val;
        start    <= 1'b1;
        @(negedge clk);
        while (!beat_taken)
            @(negedge clk);
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random(int n_items);
        int   push_pct;
        int   seg_left;
        int   r;
        req_t req;
        seg_left = 0;
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (seg_left == 0)
            begin
                // alternate fill, drain and balanced phases
                case ($urandom_range(0, 2))
                    0:       push_pct = 70;
                    1:       push_pct = 25;
                    default: push_pct = 50;
                endcase
                back_to_back = ($urandom_range(0, 2) == 0);
                seg_left     = $urandom_range(15, 60);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < push_pct)
                req = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
            else if (r < 97)
            begin
                case ($urandom_range(0, 4))
                    0, 1, 2: req = REQ_POP_FRONT;
                    3:       req = REQ_PEEK_FRONT;
                    default: req = REQ_PEEK_REAR;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       req = REQ_SPARE_5;
                    1:       req = REQ_SPARE_6;
                    default: req = REQ_SPARE_7;
                endcase
            end
            issue(req, pick_value());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_PUSH_FRONT;
        value        = '0;
        back_to_back = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty deque: every read is rejected, spare code is a no-op
        issue(REQ_POP_FRONT, pick_value());
        issue(REQ_PEEK_FRONT, pick_value());
        issue(REQ_PEEK_REAR, pick_value());
        issue(REQ_SPARE_5, pick_value());
        // single entry in and out again
        issue(REQ_PUSH_FRONT, VAL_MAX);
        issue(REQ_POP_FRONT, pick_value());
        // fill from both ends, wrapping the head below slot 0
        issue(REQ_PUSH_REAR, VAL_MIN);
        issue(REQ_PUSH_FRONT, -1);
        issue(REQ_PUSH_REAR, '0);
        issue(REQ_PUSH_FRONT, 32'sh5555_5555);
        issue(REQ_PUSH_REAR, 32'shAAAA_AAAA);
        issue(REQ_PUSH_FRONT, 32'sh0000_0001);
        issue(REQ_PUSH_REAR, VAL_MAX);
        issue(REQ_PUSH_FRONT, VAL_MIN);
        // full: both pushes rejected
        issue(REQ_PUSH_FRONT, pick_value());
        issue(REQ_PUSH_REAR, pick_value());
        issue(REQ_SPARE_6, pick_value());
        issue(REQ_PEEK_FRONT, pick_value());
        issue(REQ_PEEK_REAR, pick_value());
        issue(REQ_SPARE_7, pick_value());
        issue(REQ_POP_FRONT, pick_value());
        issue(REQ_PEEK_FRONT, pick_value());

        run_random(RANDOM_ITEMS);

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("[output_restricted_deque] OK");
        else
            $display("[output_restricted_deque] ERROR");
        $finish;
    end

endmodule
